// File: hw/rtl/sabs_pkg.sv
// Shared widths, register indexes, mode codes and reset values for the
// sensorless angle blend selector. No dependencies.
package sabs_pkg;

  localparam int SPEED_WIDTH = 24;
  localparam int ANGLE_WIDTH = 16;

  localparam int THR_W      = 23;
  localparam int RECIP_W    = 25;
  localparam int CNT_W      = 8;
  localparam int WEIGHT_W   = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'h10000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_HALF = 17'h08000;
  localparam logic [CNT_W-1:0]    CNT_MAX     = 8'hFF;

  localparam logic [THR_W-1:0]   SPEED_LOW_RST  = 23'd20480;
  localparam logic [THR_W-1:0]   SPEED_HIGH_RST = 23'd30720;
  localparam logic [RECIP_W-1:0] RECIP_RST      = 25'd419430;
  localparam logic [CNT_W-1:0]   DEBOUNCE_RST   = 8'd100;
  localparam logic [CNT_W-1:0]   SETTLE_RST     = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_LOW  = 3'd0,
    REG_SPEED_HIGH = 3'd1,
    REG_BAND_RECIP = 3'd2,
    REG_DEBOUNCE   = 3'd3,
    REG_SETTLE     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_INJ  = 2'd0,
    MODE_MIX  = 2'd1,
    MODE_FLUX = 2'd2
  } mode_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic mag;
    logic mode;
    logic wmul;
    logic load;
  } sabs_cmd_t;

endpackage

// File: hw/rtl/sabs_ctrl.sv
// Sequencing controller for the angle blend selector: steps one word through
// the datapath stages and owns both handshakes. Depends on sabs_pkg.
module sabs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sabs_pkg::sabs_cmd_t cmd_o
);
  import sabs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAG   = 5'b00010,
    ST_MODE  = 5'b00100,
    ST_WMUL  = 5'b01000,
    ST_BLEND = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load, accept;

  assign load   = (state_q == ST_BLEND) && (!out_valid_q || out_ready_i);
  // a new word may enter while the previous one is written to the output
  assign in_ready_o = (state_q == ST_IDLE) || load;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_MAG;
      ST_MAG:   state_d = ST_MODE;
      ST_MODE:  state_d = ST_WMUL;
      ST_WMUL:  state_d = ST_BLEND;
      ST_BLEND: begin
        if (load) state_d = accept ? ST_MAG : ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = accept;
  assign cmd_o.mag     = (state_q == ST_MAG);
  assign cmd_o.mode    = (state_q == ST_MODE);
  assign cmd_o.wmul    = (state_q == ST_WMUL);
  assign cmd_o.load    = load;

endmodule

// File: hw/rtl/sabs_dp.sv
// Datapath of the angle blend selector: config registers, speed magnitude,
// hysteresis mode machine, weight and blend multiplies, output register.
// Depends on sabs_pkg.
module sabs_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sabs_pkg::sabs_cmd_t                   cmd_i,
  input  logic                                  cfg_we_i,
  input  logic [sabs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sabs_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic signed [sabs_pkg::SPEED_WIDTH-1:0] hfi_speed_i,
  input  logic signed [sabs_pkg::SPEED_WIDTH-1:0] flux_speed_i,
  input  logic signed [sabs_pkg::ANGLE_WIDTH-1:0] hfi_angle_i,
  input  logic signed [sabs_pkg::ANGLE_WIDTH-1:0] flux_angle_i,
  output logic signed [sabs_pkg::ANGLE_WIDTH-1:0] rotor_angle_o,
  output logic [1:0]                            mode_o,
  output logic [sabs_pkg::WEIGHT_W-1:0]         blend_weight_o,
  output logic                                  inject_enable_o,
  output logic                                  use_fundamental_o,
  output logic                                  tracker_reseed_o
);
  import sabs_pkg::*;

  localparam int SW     = SPEED_WIDTH;
  localparam int AW     = ANGLE_WIDTH;
  localparam int CMP_W  = (SW > THR_W) ? SW : THR_W;
  localparam int PROD_W = SW + RECIP_W;
  localparam int WF_W   = PROD_W - 16;
  localparam int BP_W   = AW + WEIGHT_W + 1;

  // configuration
  logic [THR_W-1:0]   speed_low_q, speed_high_q;
  logic [RECIP_W-1:0] recip_q;
  logic [CNT_W-1:0]   dbc_limit_q, settle_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_low_q    <= SPEED_LOW_RST;
      speed_high_q   <= SPEED_HIGH_RST;
      recip_q        <= RECIP_RST;
      dbc_limit_q    <= DEBOUNCE_RST;
      settle_limit_q <= SETTLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SPEED_LOW:  speed_low_q    <= cfg_data_i[THR_W-1:0];
        REG_SPEED_HIGH: speed_high_q   <= cfg_data_i[THR_W-1:0];
        REG_BAND_RECIP: recip_q        <= cfg_data_i[RECIP_W-1:0];
        REG_DEBOUNCE:   dbc_limit_q    <= cfg_data_i[CNT_W-1:0];
        REG_SETTLE:     settle_limit_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  logic signed [SW-1:0] hspd_q, fspd_q;
  logic signed [AW-1:0] hang_q, fang_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      hspd_q <= hfi_speed_i;
      fspd_q <= flux_speed_i;
      hang_q <= hfi_angle_i;
      fang_q <= flux_angle_i;
    end
  end

  // stage 1: lesser magnitude
  logic [SW-1:0] hmag, fmag, spd_q;
  assign hmag = hspd_q[SW-1] ? (~hspd_q + 1'b1) : hspd_q;
  assign fmag = fspd_q[SW-1] ? (~fspd_q + 1'b1) : fspd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mag) spd_q <= (hmag < fmag) ? hmag : fmag;
  end

  // stage 2: mode machine with debounce and settle counting
  mode_e            mode_q, mode_d, target;
  logic [CNT_W-1:0] dbc_q, dbc_d, dbc_inc, settle_q, settle_d, settle_base;
  logic [CMP_W-1:0] spd_c, low_c, high_c, sub_c;
  logic             qual, fire, reseed, settling;
  logic signed [AW-1:0] trk;

  logic [SW-1:0]        sub_q;
  logic signed [AW-1:0] diff_q, base_q;
  logic                 blend_q, reseed_q;

  assign spd_c  = CMP_W'(spd_q);
  assign low_c  = CMP_W'(speed_low_q);
  assign high_c = CMP_W'(speed_high_q);

  always_comb begin
    qual   = 1'b0;
    target = MODE_MIX;
    unique case (mode_q)
      MODE_MIX: begin
        if (spd_c < low_c) begin
          qual   = 1'b1;
          target = MODE_INJ;
        end else if (spd_c > high_c) begin
          qual   = 1'b1;
          target = MODE_FLUX;
        end
      end
      MODE_FLUX: qual = (spd_c < high_c);
      default:   qual = (spd_c > low_c);
    endcase
  end

  assign dbc_inc = (dbc_q == CNT_MAX) ? dbc_q : dbc_q + 1'b1;
  assign fire    = qual && (dbc_inc > dbc_limit_q);
  assign dbc_d   = (qual && !fire) ? dbc_inc : '0;
  assign reseed  = fire && (mode_q == MODE_FLUX);

  always_comb begin
    if (fire) begin
      mode_d = target;
    end else if (mode_q == MODE_MIX || mode_q == MODE_FLUX) begin
      mode_d = mode_q;
    end else begin
      mode_d = MODE_INJ;
    end
  end

  // the tracker is loaded from the observer on a reseed word
  assign trk         = reseed ? fang_q : hang_q;
  assign settle_base = reseed ? '0 : settle_q;
  assign settling    = (mode_d == MODE_MIX) && (settle_base < settle_limit_q);
  assign settle_d    = settling ? settle_base + 1'b1 : settle_base;
  assign sub_c       = (spd_c > low_c) ? (spd_c - low_c) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_INJ;
      dbc_q    <= '0;
      settle_q <= '0;
    end else if (cmd_i.mode) begin
      mode_q   <= mode_d;
      dbc_q    <= dbc_d;
      settle_q <= settle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mode) begin
      sub_q    <= sub_c[SW-1:0];
      diff_q   <= fang_q - trk;
      base_q   <= (mode_d == MODE_FLUX) ? fang_q : trk;
      blend_q  <= (mode_d == MODE_MIX) && !settling;
      reseed_q <= reseed;
    end
  end

  // stage 3: weight = clamp((speed - low) * recip >> 16)
  logic [PROD_W-1:0]   wprod;
  logic [WF_W-1:0]     wfull;
  logic [WEIGHT_W-1:0] wgt_q;

  assign wprod = PROD_W'(sub_q) * PROD_W'(recip_q);
  assign wfull = wprod[PROD_W-1:16];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wmul) begin
      wgt_q <= (wfull > WF_W'(WEIGHT_ONE)) ? WEIGHT_ONE : wfull[WEIGHT_W-1:0];
    end
  end

  // stage 4: blend along the short arc, rounded half up
  logic signed [WEIGHT_W:0] wgt_s;
  logic signed [BP_W-1:0]   bprod, brnd;
  logic [WEIGHT_W-1:0]      wsel;
  logic signed [AW-1:0]     angle;

  assign wgt_s = $signed({1'b0, wgt_q});
  assign bprod = BP_W'(diff_q) * BP_W'(wgt_s);
  assign brnd  = bprod + BP_W'(32768);
  assign angle = blend_q ? (base_q + $signed(brnd[AW+15:16])) : base_q;

  always_comb begin
    if (blend_q) begin
      wsel = wgt_q;
    end else if (mode_q == MODE_FLUX) begin
      wsel = WEIGHT_ONE;
    end else begin
      wsel = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rotor_angle_o     <= angle;
      mode_o            <= mode_q;
      blend_weight_o    <= wsel;
      inject_enable_o   <= (mode_q != MODE_FLUX);
      use_fundamental_o <= (wsel < WEIGHT_HALF);
      tracker_reseed_o  <= reseed_q;
    end
  end

endmodule

// File: hw/rtl/sensorless_angle_blend_selector.sv
// Top level of the sensorless angle blend selector: joins the sequencing
// controller and the datapath. Depends on sabs_pkg, sabs_ctrl, sabs_dp.

// One word per PWM tick: two signed speeds and two angles in, one result out
// carrying the angle, mode, flux weight, injection enable, feedback choice and
// tracker reseed pulse. An accepted word is captured, then steps through
// speed magnitude, mode and counter update, weight multiply, then blend
// multiply into the output register, which waits while the output is held;
// the next word is taken in the cycle its predecessor is written out, so
// no word enters before the last one is through. Only one word is in flight,
// since the mode machine state of one word decides the next. Configuration
// writes apply at once and must be made while the block is idle; reset loads
// thresholds of 80 and 120 rad/s (Q8), a debounce and settle limit of 100.
module sensorless_angle_blend_selector (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [sabs_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [sabs_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [sabs_pkg::SPEED_WIDTH-1:0] hfi_speed_i,
  input  logic signed [sabs_pkg::SPEED_WIDTH-1:0] flux_speed_i,
  input  logic signed [sabs_pkg::ANGLE_WIDTH-1:0] hfi_angle_i,
  input  logic signed [sabs_pkg::ANGLE_WIDTH-1:0] flux_angle_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [sabs_pkg::ANGLE_WIDTH-1:0] rotor_angle_o,
  output logic [1:0]                              mode_o,
  output logic [sabs_pkg::WEIGHT_W-1:0]           blend_weight_o,
  output logic                                    inject_enable_o,
  output logic                                    use_fundamental_o,
  output logic                                    tracker_reseed_o
);
  import sabs_pkg::*;

  sabs_cmd_t cmd;

  sabs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  sabs_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .hfi_speed_i       (hfi_speed_i),
    .flux_speed_i      (flux_speed_i),
    .hfi_angle_i       (hfi_angle_i),
    .flux_angle_i      (flux_angle_i),
    .rotor_angle_o     (rotor_angle_o),
    .mode_o            (mode_o),
    .blend_weight_o    (blend_weight_o),
    .inject_enable_o   (inject_enable_o),
    .use_fundamental_o (use_fundamental_o),
    .tracker_reseed_o  (tracker_reseed_o)
  );

`ifndef SYNTHESIS
  // only one word in flight: no acceptance in the cycle after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("word accepted while previous one in progress");

  a_flux_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_o == MODE_FLUX) |->
      (!inject_enable_o && blend_weight_o == WEIGHT_ONE))
    else $error("flux mode result with injection on or partial weight");

  a_reseed_mixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tracker_reseed_o) |-> (mode_o == MODE_MIX))
    else $error("tracker reseed outside a mixed result");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (blend_weight_o <= WEIGHT_ONE && mode_o != 2'd3))
    else $error("weight above one or bad mode code");
`endif

endmodule
